/* rtl/sqlts_pkg.sv */
`default_nettype none

package sqlts_pkg;

  // token class codes as they leave the block
  typedef enum logic [4:0] {
    CLS_END       = 5'd0,
    CLS_SPACE     = 5'd1,
    CLS_COMMA     = 5'd2,
    CLS_SEMICOLON = 5'd3,
    CLS_DOT       = 5'd4,
    CLS_LPAREN    = 5'd5,
    CLS_RPAREN    = 5'd6,
    CLS_PLUS      = 5'd7,
    CLS_MINUS     = 5'd8,
    CLS_STAR      = 5'd9,
    CLS_NUMBER    = 5'd10,
    CLS_STRING    = 5'd11,
    CLS_IDENT     = 5'd12,
    CLS_INVALID   = 5'd13,
    CLS_AS        = 5'd14,
    CLS_FROM      = 5'd15,
    CLS_SELECT    = 5'd16
  } tok_class_e;

  typedef struct packed {
    tok_class_e  cls;
    logic [15:0] begin_pos;
    logic [15:0] end_pos;
    logic [15:0] text_start;
    logic [15:0] text_len;
    logic [31:0] num_value;
    logic        last;
  } tok_t;

  // tokens produced by one byte, compacted: first is valid when cnt != 0
  typedef struct packed {
    logic [1:0] cnt;
    tok_t       first;
    tok_t       second;
  } step_res_t;

endpackage

`default_nettype wire

/* rtl/sqlts_lexer.sv */
`default_nettype none

module sqlts_lexer #(
  parameter int POS_BITS = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  step_valid_i,
  input  wire logic [7:0]            ch_i,
  input  wire logic                  at_end_i,
  output sqlts_pkg::step_res_t       res_o
);

  typedef enum logic [2:0] {
    M_IDLE,
    M_SPACE,
    M_MINUS,
    M_NUM,
    M_SQUOTE,
    M_DQUOTE,
    M_WORD
  } mode_e;

  localparam logic [2:0] KW_LEN_AS     = 3'd2;
  localparam logic [2:0] KW_LEN_FROM   = 3'd4;
  localparam logic [2:0] KW_LEN_SELECT = 3'd6;
  localparam logic [2:0] LEN_MAX       = 3'd7;
  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};
  localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;
  localparam logic [31:0] POS_LIMIT = 32'h7FFF_FFFF;

  mode_e               mode_q, mode_d;
  logic [POS_BITS-1:0] pos_q, pos_d;
  logic [POS_BITS-1:0] start_q, start_d;
  logic [31:0]         acc_q, acc_d;
  logic                neg_q, neg_d;
  logic [2:0]          hits_q, hits_d;
  logic [2:0]          len_q, len_d;

  function automatic logic [POS_BITS-1:0] pos_inc(input logic [POS_BITS-1:0] p);
    return (p == POS_MAX) ? p : p + 1'b1;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  // keyword letters that still match at this offset, one bit per keyword
  function automatic logic [2:0] kw_match(input logic [7:0] u, input logic [2:0] n);
    logic [2:0] m;
    m[0] = (n == 3'd0 && u == "A") || (n == 3'd1 && u == "S");
    m[1] = (n == 3'd0 && u == "F") || (n == 3'd1 && u == "R") ||
           (n == 3'd2 && u == "O") || (n == 3'd3 && u == "M");
    m[2] = (n == 3'd0 && u == "S") || (n == 3'd1 && u == "E") ||
           (n == 3'd2 && u == "L") || (n == 3'd3 && u == "E") ||
           (n == 3'd4 && u == "C") || (n == 3'd5 && u == "T");
    return m;
  endfunction

  function automatic logic [5:0] feed_word(input logic [2:0] hits, input logic [2:0] n,
                                           input logic [7:0] c);
    logic [7:0] u;
    logic [2:0] n_next;
    u = (c >= "a" && c <= "z") ? c - 8'd32 : c;
    n_next = (n < LEN_MAX) ? n + 3'd1 : n;
    return {hits & kw_match(u, n), n_next};
  endfunction

  function automatic sqlts_pkg::tok_t mk_tok(input sqlts_pkg::tok_class_e cls,
                                             input logic [POS_BITS-1:0] b,
                                             input logic [POS_BITS-1:0] e,
                                             input logic [POS_BITS-1:0] ts,
                                             input logic [POS_BITS-1:0] tl,
                                             input logic [31:0] val,
                                             input logic last);
    sqlts_pkg::tok_t t;
    t.cls        = cls;
    t.begin_pos  = 16'(b);
    t.end_pos    = 16'(e);
    t.text_start = 16'(ts);
    t.text_len   = 16'(tl);
    t.num_value  = val;
    t.last       = last;
    return t;
  endfunction

  logic [POS_BITS-1:0] p_inc, b_inc, quote_len, str_len, word_len;
  logic [7:0]          digit;
  logic [35:0]         acc_x10;
  logic [31:0]         acc_add, num_out;
  logic [5:0]          fed_cont, fed_start;
  sqlts_pkg::tok_class_e word_cls;
  sqlts_pkg::tok_class_e single_cls;
  sqlts_pkg::tok_t     close_tok, st_tok, e0, e1;
  logic                close_v, st_emit, e0_v, e1_v, restart;
  mode_e               st_mode;
  logic [31:0]         st_acc;
  logic                st_neg;
  logic [2:0]          st_hits, st_len;

  // shared arithmetic for the current byte
  always_comb begin
    p_inc     = pos_inc(pos_q);
    b_inc     = pos_inc(start_q);
    quote_len = p_inc - start_q;
    str_len   = (quote_len >= POS_BITS'(2)) ? quote_len - POS_BITS'(2) : '0;
    word_len  = pos_q - start_q;
    digit     = ch_i - "0";
    acc_x10   = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + 36'(digit[3:0]);
    acc_add   = (acc_x10 > 36'(MAG_LIMIT)) ? MAG_LIMIT : acc_x10[31:0];
    if (neg_q) begin
      num_out = (acc_q >= MAG_LIMIT) ? MAG_LIMIT : 32'd0 - acc_q;
    end else begin
      num_out = (acc_q > POS_LIMIT) ? POS_LIMIT : acc_q;
    end
    fed_cont  = feed_word(hits_q, len_q, ch_i);
    fed_start = feed_word(3'b111, 3'd0, ch_i);
  end

  // pending token closed at the current offset
  always_comb begin
    if (hits_q[0] && len_q == KW_LEN_AS) begin
      word_cls = sqlts_pkg::CLS_AS;
    end else if (hits_q[1] && len_q == KW_LEN_FROM) begin
      word_cls = sqlts_pkg::CLS_FROM;
    end else if (hits_q[2] && len_q == KW_LEN_SELECT) begin
      word_cls = sqlts_pkg::CLS_SELECT;
    end else begin
      word_cls = sqlts_pkg::CLS_IDENT;
    end
    close_v = (mode_q != M_IDLE);
    unique case (mode_q)
      M_SPACE: close_tok = mk_tok(sqlts_pkg::CLS_SPACE, start_q, pos_q, start_q, '0, '0, 1'b0);
      M_MINUS: close_tok = mk_tok(sqlts_pkg::CLS_MINUS, start_q, pos_q, start_q, '0, '0, 1'b0);
      M_NUM: close_tok = mk_tok(sqlts_pkg::CLS_NUMBER, start_q, pos_q, start_q, '0, num_out,
                                1'b0);
      M_SQUOTE, M_DQUOTE: close_tok = mk_tok(sqlts_pkg::CLS_INVALID, start_q, pos_q, start_q,
                                             '0, '0, 1'b0);
      M_WORD: close_tok = mk_tok(word_cls, start_q, pos_q, start_q,
                                 (word_cls == sqlts_pkg::CLS_IDENT) ? word_len : '0, '0, 1'b0);
      default: close_tok = mk_tok(sqlts_pkg::CLS_END, '0, '0, '0, '0, '0, 1'b0);
    endcase
  end

  // token that the current byte opens
  always_comb begin
    unique case (ch_i)
      ",":     single_cls = sqlts_pkg::CLS_COMMA;
      ";":     single_cls = sqlts_pkg::CLS_SEMICOLON;
      ".":     single_cls = sqlts_pkg::CLS_DOT;
      "(":     single_cls = sqlts_pkg::CLS_LPAREN;
      ")":     single_cls = sqlts_pkg::CLS_RPAREN;
      "+":     single_cls = sqlts_pkg::CLS_PLUS;
      "*":     single_cls = sqlts_pkg::CLS_STAR;
      default: single_cls = sqlts_pkg::CLS_INVALID;
    endcase
    st_mode = M_IDLE;
    st_acc  = acc_q;
    st_neg  = neg_q;
    st_hits = hits_q;
    st_len  = len_q;
    st_emit = 1'b0;
    st_tok  = mk_tok(single_cls, pos_q, p_inc, pos_q, '0, '0, 1'b0);
    priority if (single_cls != sqlts_pkg::CLS_INVALID) begin
      st_emit = 1'b1;
    end else if (is_space(ch_i)) begin
      st_mode = M_SPACE;
    end else if (ch_i == "-") begin
      st_mode = M_MINUS;
    end else if (is_digit(ch_i)) begin
      st_mode = M_NUM;
      st_neg  = 1'b0;
      st_acc  = 32'(digit[3:0]);
    end else if (ch_i == "'") begin
      st_mode = M_SQUOTE;
    end else if (ch_i == "\"") begin
      st_mode = M_DQUOTE;
    end else if (is_alpha(ch_i)) begin
      st_mode = M_WORD;
      {st_hits, st_len} = fed_start;
    end else begin
      st_emit = 1'b1;
    end
  end

  // per-byte transition
  always_comb begin
    mode_d  = mode_q;
    pos_d   = p_inc;
    start_d = start_q;
    acc_d   = acc_q;
    neg_d   = neg_q;
    hits_d  = hits_q;
    len_d   = len_q;
    e0_v    = 1'b0;
    e1_v    = 1'b0;
    e0      = close_tok;
    e1      = st_tok;
    restart = 1'b0;
    if (at_end_i) begin
      e0_v    = close_v;
      e1_v    = 1'b1;
      e1      = mk_tok(sqlts_pkg::CLS_END, pos_q, pos_q, '0, '0, '0, 1'b1);
      mode_d  = M_IDLE;
      pos_d   = '0;
      start_d = '0;
      acc_d   = '0;
      neg_d   = 1'b0;
      hits_d  = 3'b111;
      len_d   = '0;
    end else begin
      unique case (mode_q)
        M_SPACE: restart = !is_space(ch_i);
        M_MINUS: begin
          if (is_digit(ch_i)) begin
            mode_d = M_NUM;
            neg_d  = 1'b1;
            acc_d  = 32'(digit[3:0]);
          end else begin
            restart = 1'b1;
          end
        end
        M_NUM: begin
          if (is_digit(ch_i)) begin
            acc_d = acc_add;
          end else begin
            restart = 1'b1;
          end
        end
        M_WORD: begin
          if (is_alpha(ch_i) || is_digit(ch_i)) begin
            {hits_d, len_d} = fed_cont;
          end else begin
            restart = 1'b1;
          end
        end
        M_SQUOTE: begin
          if (ch_i == "'") begin
            e0_v   = 1'b1;
            e0     = mk_tok(sqlts_pkg::CLS_STRING, start_q, p_inc, b_inc, str_len, '0, 1'b0);
            mode_d = M_IDLE;
          end
        end
        M_DQUOTE: begin
          if (ch_i == "\"") begin
            e0_v   = 1'b1;
            e0     = mk_tok(sqlts_pkg::CLS_IDENT, start_q, p_inc, start_q, quote_len, '0,
                            1'b0);
            mode_d = M_IDLE;
          end
        end
        M_IDLE: restart = 1'b1;
        default: restart = 1'b1;
      endcase
      if (restart) begin
        e0_v    = close_v;
        e0      = close_tok;
        e1_v    = st_emit;
        mode_d  = st_mode;
        start_d = pos_q;
        acc_d   = st_acc;
        neg_d   = st_neg;
        hits_d  = st_hits;
        len_d   = st_len;
      end
    end
  end

  always_comb begin
    res_o.first  = e0_v ? e0 : e1;
    res_o.second = e1;
    res_o.cnt    = step_valid_i ? (2'(e0_v) + 2'(e1_v)) : 2'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= M_IDLE;
      pos_q   <= '0;
      start_q <= '0;
      acc_q   <= '0;
      neg_q   <= 1'b0;
      hits_q  <= 3'b111;
      len_q   <= '0;
    end else if (step_valid_i) begin
      mode_q  <= mode_d;
      pos_q   <= pos_d;
      start_q <= start_d;
      acc_q   <= acc_d;
      neg_q   <= neg_d;
      hits_q  <= hits_d;
      len_q   <= len_d;
    end
  end

`ifndef SYNTH
  a_end_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_valid_i && at_end_i) |=> (pos_q == '0 && mode_q == M_IDLE))
    else $error("scanner state not cleared after end of text");

  a_quote_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_valid_i && !at_end_i && mode_q == M_SQUOTE && ch_i != "'") |-> (res_o.cnt == 2'd0))
    else $error("token emitted from inside a quoted string");

  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_valid_i && at_end_i) |-> (res_o.cnt != 2'd0 && res_o.second.last))
    else $error("end of text without end token");
`endif

endmodule

`default_nettype wire

/* rtl/sqlts_fifo.sv */
`default_nettype none

module sqlts_fifo (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire sqlts_pkg::step_res_t push_i,
  output logic                      room_o,
  output logic                      m_valid_o,
  input  wire logic                 m_ready_i,
  output sqlts_pkg::tok_t           m_tok_o
);

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  sqlts_pkg::tok_t  mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             pop;

  assign pop       = m_valid_o && m_ready_i;
  assign m_valid_o = (count_q != '0);
  assign m_tok_o   = mem_q[rd_ptr_q];
  // two free slots so that any byte can be taken
  assign room_o    = (count_q <= CNT_W'(DEPTH - 2));

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.first;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_ptr_q + PTR_W'(1)] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PTR_W'(push_i.cnt);
      rd_ptr_q <= rd_ptr_q + PTR_W'(pop);
      count_q  <= count_q + CNT_W'(push_i.cnt) - CNT_W'(pop);
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.cnt != 2'd0) |-> room_o)
    else $error("token queue written without room");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.cnt == 2'd0 && !pop) |=> $stable(count_q))
    else $error("token queue count moved without push or pop");
`endif

endmodule

`default_nettype wire

/* rtl/sql_token_scanner_core.sv */
`default_nettype none

// streaming lexer for query text: one text byte enters per transaction on the
// slave side (tlast marks end of text and closes the pending token), and the
// master side carries one token per transaction. A byte is taken every cycle
// as long as the token queue keeps two free slots; a byte yields zero, one or
// two tokens, and the token queue drains at one token per cycle while the
// master side is ready, so a run of bytes that each close one token and open
// another is slowed by the queue. A byte passes through an input register,
// then the scanner logic writing the token queue that drives the master side.
// Offsets count from the first byte after reset or after end of text and
// saturate at 2^POS_BITS - 1; they are reported in 16 bits.
module sql_token_scanner_core #(
  parameter int POS_BITS = 16
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  wire logic [7:0]   s_axis_tdata_i,   // [7:0] ch
  input  wire logic         s_axis_tlast_i,   // at_end
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  // [15:0] begin_pos, [31:16] end_pos, [47:32] text_start, [63:48] text_len,
  // [95:64] num_value
  output logic [95:0]       m_axis_tdata_o,
  output logic [4:0]        m_axis_tuser_o,   // [4:0] tok_class
  output logic              m_axis_tlast_o    // last, set on the end token
);

  // input register
  logic       in_valid_q;
  logic [7:0] in_ch_q;
  logic       in_end_q;

  logic                 room;
  logic                 consume;
  sqlts_pkg::step_res_t step_res;
  sqlts_pkg::tok_t      out_tok;

  // the byte held in the input register is scanned once the queue has room
  assign consume         = in_valid_q && room;
  assign s_axis_tready_o = !in_valid_q || room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_valid_q <= 1'b1;
    end else if (consume) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_ch_q  <= s_axis_tdata_i;
      in_end_q <= s_axis_tlast_i;
    end
  end

  // scanner state and per-byte token decision
  sqlts_lexer #(
    .POS_BITS(POS_BITS)
  ) u_lexer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_valid_i(consume),
    .ch_i        (in_ch_q),
    .at_end_i    (in_end_q),
    .res_o       (step_res)
  );

  // token queue, doubles as the output register
  sqlts_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (step_res),
    .room_o   (room),
    .m_valid_o(m_axis_tvalid_o),
    .m_ready_i(m_axis_tready_i),
    .m_tok_o  (out_tok)
  );

  assign m_axis_tdata_o = {out_tok.num_value, out_tok.text_len, out_tok.text_start,
                           out_tok.end_pos, out_tok.begin_pos};
  assign m_axis_tuser_o = out_tok.cls;
  assign m_axis_tlast_o = out_tok.last;

`ifndef SYNTH
  a_hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !room) |=> (in_valid_q && $stable(in_ch_q) && $stable(in_end_q)))
    else $error("held input byte lost while token queue was full");
`endif

endmodule

`default_nettype wire
